// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/fsla_pkg.sv =====
// types and constants of the free segment list allocator
`default_nettype none
package fsla_pkg;
	localparam int MAX_SEG = 16;
	localparam int IDX_W = $clog2(MAX_SEG);
	localparam int CNT_W = IDX_W + 1;
	localparam int ADDR_W = 16;
	localparam int LEN_W = ADDR_W + 1;
	localparam logic [LEN_W-1:0] SPACE = {1'b1, {ADDR_W{1'b0}}};

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

	typedef struct packed {
		logic operation;
		logic [ADDR_W-1:0] req_start;
		logic [LEN_W-1:0] req_length;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [ADDR_W-1:0] seg_start;
		logic [LEN_W-1:0] seg_length;
		logic list_empty;
		logic last;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [LEN_W-1:0] len;
	} seg_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic commit;
		logic emit;
	} fsla_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic list_end;
		logic out_free;
	} fsla_sts_t;
endpackage
`default_nettype wire

// ===== rtl/free_segment_list_allocator.sv =====
// top level of the free segment list allocator
//  channel  signals                 direction  item
//  req      req_valid req_stall req in         one allocate or free
//  rsp      rsp_valid rsp_stall rsp out        one listed segment
//  cfg      cfg_we cfg_wdata        in         total_size write
// an item is accepted, then scanned over the n table entries one entry per cycle
// (an allocate that splits, or a free that adds or extends the entry before it,
// takes one more scan step; a reject or full ends the scan early), committed,
// and listed at one segment per cycle while the result is not stalled
// reset gives one free segment covering 65536 units, no clearing pass
// a stalled result holds the listing; the next item is taken once listing ends
`default_nettype none
`include "assert_macros.svh"
module free_segment_list_allocator
	import fsla_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire req_t req,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output rsp_t rsp,
	input wire logic cfg_we,
	input wire logic [LEN_W-1:0] cfg_wdata
);
	fsla_cmd_t cmd;
	fsla_sts_t sts;

	fsla_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.sts(sts),
		.cmd(cmd)
	);

	fsla_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd(cmd),
		.sts(sts),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	`ASSERT_IMPL(a_emit_free, clk, arst_n, cmd.emit, !rsp_valid || !rsp_stall)
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && !req_stall, req_stall)
	`ASSERT_IMPL(a_empty_last, clk, arst_n, rsp_valid && rsp.list_empty, rsp.last)
endmodule
`default_nettype wire

// ===== rtl/fsla_ctrl.sv =====
// controller state machine of the free segment list allocator
`default_nettype none
module fsla_ctrl
	import fsla_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire fsla_sts_t sts,
	output fsla_cmd_t cmd
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;
	localparam logic [1:0] S_LIST = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		req_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.start = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d = S_LIST;
			end
			S_LIST: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.list_end) state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule
`default_nettype wire

// ===== rtl/fsla_dp.sv =====
// datapath: ping-pong segment table, scan step logic and result register
`default_nettype none
module fsla_dp
	import fsla_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire req_t req,
	input wire logic cfg_we,
	input wire logic [LEN_W-1:0] cfg_wdata,
	input wire fsla_cmd_t cmd,
	output fsla_sts_t sts,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output rsp_t rsp
);
	seg_t mem [2*MAX_SEG];

	logic [LEN_W-1:0] ts_q;
	logic [CNT_W-1:0] cnt_q;
	logic init_q;
	logic bank_q;
	logic op_q;
	logic zero_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic [CNT_W-1:0] wr_idx_q;
	logic hv_q;
	logic hit_q;
	logic split_q;
	logic [1:0] status_q;
	logic rsp_valid_q;
	logic [ADDR_W-1:0] s_q;
	logic [LEN_W-1:0] l_q;
	seg_t h_q;
	rsp_t rsp_q;

	logic [LEN_W-1:0] room;
	logic [LEN_W-1:0] l_in;
	logic [LEN_W-1:0] cfg_clip;
	logic [IDX_W:0] rd_addr;
	seg_t ent;
	logic at_end;
	logic full;
	logic [LEN_W:0] ent_end;
	logic [LEN_W:0] ent_s;
	logic [LEN_W:0] e_w;
	logic [LEN_W:0] s_w;
	logic [LEN_W:0] h_end;
	logic tp;
	logic tc;
	logic ins_here;
	logic wr_en;
	seg_t h_d;
	logic hv_d;
	logic hit_d;
	logic split_d;
	logic adv;
	logic done;
	logic [1:0] st_d;
	rsp_t rsp_d;

	assign room = SPACE - {1'b0, req.req_start};
	assign l_in = (req.operation == OP_FREE && req.req_length > room) ? room : req.req_length;
	assign cfg_clip = (cfg_wdata > SPACE) ? SPACE : cfg_wdata;

	assign rd_addr = {bank_q, rd_idx_q[IDX_W-1:0]};
	always_comb begin
		if (init_q && rd_idx_q == '0) begin
			ent.start = '0;
			ent.len = ts_q;
		end else begin
			ent = mem[rd_addr];
		end
	end

	assign at_end = (rd_idx_q == cnt_q);
	assign full = (cnt_q == CNT_W'(MAX_SEG));
	assign ent_s = {2'b00, ent.start};
	assign ent_end = ent_s + {1'b0, ent.len};
	assign s_w = {2'b00, s_q};
	assign e_w = s_w + {1'b0, l_q};
	assign h_end = {2'b00, h_q.start} + {1'b0, h_q.len};
	assign tp = hv_q && (h_end == s_w);
	assign tc = !at_end && (e_w == ent_s);
	assign ins_here = !hit_q && (at_end || ent.start > s_q);

	always_comb begin
		wr_en = 1'b0;
		h_d = h_q;
		hv_d = hv_q;
		hit_d = hit_q;
		split_d = 1'b0;
		adv = 1'b0;
		done = 1'b0;
		st_d = status_q;
		if (zero_q) begin
			done = 1'b1;
		end else if (op_q == OP_ALLOC) begin
			if (split_q) begin
				wr_en = 1'b1;
				h_d.start = e_w[ADDR_W-1:0];
				h_d.len = LEN_W'(ent_end - e_w);
				hv_d = 1'b1;
				adv = 1'b1;
			end else if (at_end) begin
				done = 1'b1;
				if (!hit_q) st_d = ST_REJECT;
				else wr_en = hv_q;
			end else if (!hit_q && ent_end > s_w) begin
				hit_d = 1'b1;
				if (s_w < ent_s || e_w > ent_end) begin
					st_d = ST_REJECT;
					done = 1'b1;
				end else if (s_w == ent_s && e_w == ent_end) begin
					wr_en = hv_q;
					hv_d = 1'b0;
					adv = 1'b1;
				end else if (s_w == ent_s) begin
					wr_en = hv_q;
					h_d.start = e_w[ADDR_W-1:0];
					h_d.len = LEN_W'(ent_end - e_w);
					hv_d = 1'b1;
					adv = 1'b1;
				end else if (e_w == ent_end) begin
					wr_en = hv_q;
					h_d.start = ent.start;
					h_d.len = ent.len - l_q;
					hv_d = 1'b1;
					adv = 1'b1;
				end else if (full) begin
					st_d = ST_FULL;
					done = 1'b1;
				end else begin
					wr_en = hv_q;
					h_d.start = ent.start;
					h_d.len = {1'b0, s_q} - {1'b0, ent.start};
					hv_d = 1'b1;
					split_d = 1'b1;
				end
			end else begin
				wr_en = hv_q;
				h_d = ent;
				hv_d = 1'b1;
				adv = 1'b1;
			end
		end else begin
			if (at_end && hit_q) begin
				wr_en = hv_q;
				done = 1'b1;
			end else if (ins_here) begin
				hit_d = 1'b1;
				if (tp && tc) begin
					h_d.len = h_q.len + l_q + ent.len;
					adv = 1'b1;
				end else if (tp) begin
					h_d.len = h_q.len + l_q;
				end else if (tc) begin
					wr_en = hv_q;
					h_d.start = s_q;
					h_d.len = ent.len + l_q;
					hv_d = 1'b1;
					adv = 1'b1;
				end else if (full) begin
					st_d = ST_FULL;
					done = 1'b1;
				end else begin
					wr_en = hv_q;
					h_d.start = s_q;
					h_d.len = l_q;
					hv_d = 1'b1;
				end
			end else begin
				wr_en = hv_q;
				h_d = ent;
				hv_d = 1'b1;
				adv = 1'b1;
			end
		end
	end

	always_comb begin
		rsp_d.status = status_q;
		if (cnt_q == '0) begin
			rsp_d.seg_start = '0;
			rsp_d.seg_length = '0;
			rsp_d.list_empty = 1'b1;
			rsp_d.last = 1'b1;
		end else begin
			rsp_d.seg_start = ent.start;
			rsp_d.seg_length = ent.len;
			rsp_d.list_empty = 1'b0;
			rsp_d.last = (rd_idx_q + CNT_W'(1) == cnt_q);
		end
	end

	assign sts.scan_done = done;
	assign sts.list_end = rsp_d.last;
	assign sts.out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q <= SPACE;
			cnt_q <= CNT_W'(1);
			init_q <= 1'b1;
			bank_q <= 1'b0;
			op_q <= OP_ALLOC;
			zero_q <= 1'b0;
			rd_idx_q <= '0;
			wr_idx_q <= '0;
			hv_q <= 1'b0;
			hit_q <= 1'b0;
			split_q <= 1'b0;
			status_q <= ST_DONE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ts_q <= cfg_clip;
				cnt_q <= (cfg_clip == '0) ? '0 : CNT_W'(1);
				init_q <= 1'b1;
			end
			if (cmd.start) begin
				op_q <= req.operation;
				zero_q <= (l_in == '0);
				rd_idx_q <= '0;
				wr_idx_q <= '0;
				hv_q <= 1'b0;
				hit_q <= 1'b0;
				split_q <= 1'b0;
				status_q <= ST_DONE;
			end
			if (cmd.scan) begin
				hv_q <= hv_d;
				hit_q <= hit_d;
				split_q <= split_d;
				status_q <= st_d;
				if (adv) rd_idx_q <= rd_idx_q + CNT_W'(1);
				if (wr_en) wr_idx_q <= wr_idx_q + CNT_W'(1);
			end
			if (cmd.commit) begin
				rd_idx_q <= '0;
				if (status_q == ST_DONE && !zero_q) begin
					bank_q <= ~bank_q;
					cnt_q <= wr_idx_q;
					init_q <= 1'b0;
				end
			end
			if (cmd.emit) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			s_q <= req.req_start;
			l_q <= l_in;
		end
		if (cmd.scan) begin
			h_q <= h_d;
			if (wr_en) mem[{~bank_q, wr_idx_q[IDX_W-1:0]}] <= h_q;
		end
		if (cmd.emit) rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// testbench for the free segment list allocator: predicts the free list listing per item
`default_nettype none
module tb_top;
	import fsla_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [LEN_W-1:0] cfg_wdata = '0;

	free_segment_list_allocator u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow copy of the free table
	logic [LEN_W:0] region_size;
	logic [LEN_W:0] seg_base [MAX_SEG];
	logic [LEN_W:0] seg_len [MAX_SEG];
	int seg_count;
	rsp_t listing_q[$];
	int fail_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int idle_cycles = 0;

	function automatic void reset_table(logic [LEN_W:0] size);
		region_size = (size > SPACE) ? SPACE : size;
		for (int k = 0; k < MAX_SEG; k++) begin
			seg_base[k] = '0;
			seg_len[k] = '0;
		end
		seg_len[0] = region_size;
		seg_count = (region_size == 0) ? 0 : 1;
	endfunction

	function automatic void drop_entry(int i);
		for (int k = i; k + 1 < seg_count; k++) begin
			seg_base[k] = seg_base[k + 1];
			seg_len[k] = seg_len[k + 1];
		end
		seg_count--;
	endfunction

	function automatic void add_entry(int i, logic [LEN_W:0] s, logic [LEN_W:0] l);
		for (int k = seg_count; k > i; k--) begin
			seg_base[k] = seg_base[k - 1];
			seg_len[k] = seg_len[k - 1];
		end
		seg_base[i] = s;
		seg_len[i] = l;
		seg_count++;
	endfunction

	function automatic logic [1:0] claim_range(logic [LEN_W:0] s, logic [LEN_W:0] l);
		int i;
		logic [LEN_W:0] cs, ce, e;
		i = 0;
		e = s + l;
		if (l == 0)
			return ST_DONE;
		while (i < seg_count && seg_base[i] + seg_len[i] <= s)
			i++;
		if (i >= seg_count)
			return ST_REJECT;
		cs = seg_base[i];
		ce = cs + seg_len[i];
		if (s < cs || e > ce)
			return ST_REJECT;
		if (s == cs && e == ce) begin
			drop_entry(i);
		end else if (s == cs) begin
			seg_base[i] = e;
			seg_len[i] -= l;
		end else if (e == ce) begin
			seg_len[i] -= l;
		end else begin
			if (seg_count >= MAX_SEG)
				return ST_FULL;
			seg_len[i] = s - cs;
			add_entry(i + 1, e, ce - e);
		end
		return ST_DONE;
	endfunction

	function automatic logic [1:0] release_range(logic [LEN_W:0] s, logic [LEN_W:0] l);
		int i;
		bit tp, tc;
		i = 0;
		tp = 0;
		tc = 0;
		if (l > SPACE - s)
			l = SPACE - s;
		if (l == 0)
			return ST_DONE;
		while (i < seg_count && seg_base[i] <= s)
			i++;
		if (i > 0)
			tp = (seg_base[i - 1] + seg_len[i - 1] == s);
		if (i < seg_count)
			tc = (s + l == seg_base[i]);
		if (tp && tc) begin
			seg_len[i - 1] += l + seg_len[i];
			drop_entry(i);
		end else if (tp) begin
			seg_len[i - 1] += l;
		end else if (tc) begin
			seg_base[i] = s;
			seg_len[i] += l;
		end else begin
			if (seg_count >= MAX_SEG)
				return ST_FULL;
			add_entry(i, s, l);
		end
		return ST_DONE;
	endfunction

	function automatic void predict_listing(req_t r);
		logic [1:0] st;
		rsp_t x;
		if (r.operation == OP_FREE)
			st = release_range({1'b0, r.req_start}, {1'b0, r.req_length});
		else
			st = claim_range({1'b0, r.req_start}, {1'b0, r.req_length});
		if (seg_count == 0) begin
			x = '0;
			x.status = st;
			x.list_empty = 1'b1;
			x.last = 1'b1;
			listing_q.push_back(x);
		end else begin
			for (int k = 0; k < seg_count; k++) begin
				x.status = st;
				x.seg_start = seg_base[k][ADDR_W-1:0];
				x.seg_length = seg_len[k][LEN_W-1:0];
				x.list_empty = 1'b0;
				x.last = (k + 1 == seg_count);
				listing_q.push_back(x);
			end
		end
	endfunction

	// result checker and receiver stalls
	always @(posedge clk) begin
		rsp_t exp_r;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (listing_q.size() == 0) begin
				$error("unexpected result item");
				fail_count++;
			end else begin
				exp_r = listing_q.pop_front();
				if (rsp.status !== exp_r.status) begin
					$error("status exp %0d got %0d", exp_r.status, rsp.status);
					fail_count++;
				end
				if (rsp.seg_start !== exp_r.seg_start) begin
					$error("seg_start exp %0d got %0d", exp_r.seg_start, rsp.seg_start);
					fail_count++;
				end
				if (rsp.seg_length !== exp_r.seg_length) begin
					$error("seg_length exp %0d got %0d", exp_r.seg_length, rsp.seg_length);
					fail_count++;
				end
				if (rsp.list_empty !== exp_r.list_empty) begin
					$error("list_empty exp %0d got %0d", exp_r.list_empty, rsp.list_empty);
					fail_count++;
				end
				if (rsp.last !== exp_r.last) begin
					$error("last exp %0d got %0d", exp_r.last, rsp.last);
					fail_count++;
				end
			end
		end
		rsp_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_item(logic op, logic [ADDR_W-1:0] s, logic [LEN_W-1:0] l);
		req_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		r.operation = op;
		r.req_start = s;
		r.req_length = l;
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predict_listing(r);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (listing_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_size(logic [LEN_W-1:0] v);
		drain();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		reset_table({1'b0, v});
	endtask

	task automatic test_directed();
		send_item(OP_ALLOC, 16'd0, 17'd0);
		send_item(OP_FREE, 16'd5, 17'd0);
		send_item(OP_ALLOC, 16'd100, 17'd50);
		send_item(OP_ALLOC, 16'd0, 17'd10);
		send_item(OP_ALLOC, 16'd65500, 17'd36);
		send_item(OP_ALLOC, 16'd65535, 17'd2);
		send_item(OP_ALLOC, 16'd5, 17'd1);
		send_item(OP_FREE, 16'd100, 17'd50);
		send_item(OP_FREE, 16'd0, 17'd5);
		send_item(OP_FREE, 16'd5, 17'd5);
		send_item(OP_FREE, 16'd65500, 17'd65536);
		send_item(OP_ALLOC, 16'd0, 17'd65536);
		send_item(OP_ALLOC, 16'd0, 17'd1);
		send_item(OP_FREE, 16'd65535, 17'd1);
		send_item(OP_FREE, 16'd0, 17'd65535);
		for (int k = 0; k < 17; k++)
			send_item(OP_ALLOC, 16'(k * 4 + 1), 17'd1);
		for (int k = 0; k < 17; k++)
			send_item(OP_FREE, 16'(k * 4 + 1), 17'd1);
	endtask

	task automatic test_size_extremes();
		write_size(17'd0);
		send_item(OP_FREE, 16'd3, 17'd4);
		send_item(OP_ALLOC, 16'd3, 17'd4);
		write_size(17'd1);
		send_item(OP_ALLOC, 16'd0, 17'd1);
		send_item(OP_FREE, 16'd0, 17'd1);
		write_size(17'h1ffff);
		send_item(OP_ALLOC, 16'hffff, 17'd1);
		write_size(17'd65536);
	endtask

	task automatic test_random(int n, int size);
		logic [ADDR_W-1:0] s;
		logic [LEN_W-1:0] l;
		write_size(17'(size));
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(9) == 0) begin
				s = 16'($urandom());
				l = 17'($urandom());
			end else begin
				s = 16'($urandom_range(size > 0 ? size - 1 : 0));
				l = 17'($urandom_range(1, (size > 64) ? 64 : 8));
			end
			send_item(1'($urandom_range(1)), s, l);
		end
	endtask

	initial begin
		reset_table(18'd65536);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_size_extremes();
		test_random(110, 256);
		drain();
		send_idle_pct = 61;
		test_random(110, 1000);
		send_idle_pct = 0;
		recv_stall_pct = 61;
		test_random(110, 65536);
		send_idle_pct = 14;
		recv_stall_pct = 14;
		test_random(76, 200);
		drain();
		if (fail_count == 0 && listing_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire
